@@ rtl/hfa_pkg.sv @@
// Shared types and constants of the H.264 RTP FU-A packetizer.
// No dependencies; every other file of the block depends on it.
package hfa_pkg;

  localparam int unsigned LEN_W          = 21;
  localparam int unsigned MAXP_W         = 11;
  localparam int unsigned STEP_W         = 17;
  localparam int unsigned SEQ_W          = 16;
  localparam int unsigned TS_W           = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 17;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QPTR_W         = $clog2(QDEPTH);
  localparam int unsigned QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0]  MAX_UNIT_BYTES = LEN_W'(1048576);
  localparam logic [MAXP_W-1:0] MIN_PAYLOAD    = MAXP_W'(16);

  localparam logic [MAXP_W-1:0] MAXP_RESET     = MAXP_W'(1400);
  localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(3600);
  localparam logic              SKIP_RESET     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TS_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PSETS  = 2'd2;

  localparam logic [7:0] NRI_MASK   = 8'h60;
  localparam logic [7:0] TYPE_MASK  = 8'h1F;
  localparam logic [7:0] FU_A_TYPE  = 8'd28;
  localparam logic [7:0] FU_S_BIT   = 8'h80;
  localparam logic [7:0] FU_E_BIT   = 8'h40;
  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [4:0] NAL_PPS    = 5'd8;

  typedef struct packed {
    logic [7:0]       data;
    logic [7:0]       fu_ind;
    logic [7:0]       fu_hdr;
    logic             prefix;
    logic             pkt_end;
    logic             frag;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
  } hfa_cmd_t;

endpackage

@@ rtl/hfa_if.sv @@
// Channel interfaces of the packetizer: unit bytes in, payload bytes out,
// configuration writes. Depends on hfa_pkg.
interface hfa_in_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                unit_byte;
  logic [hfa_pkg::LEN_W-1:0] unit_length;
  modport source (output valid, output unit_byte, output unit_length, input ready);
  modport sink (input valid, input unit_byte, input unit_length, output ready);
endinterface

interface hfa_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                payload_byte;
  logic [hfa_pkg::SEQ_W-1:0] sequence_number;
  logic [hfa_pkg::TS_W-1:0]  timestamp;
  logic                      packet_end;
  logic                      fragmented;
  logic                      run_last;
  modport source (output valid, output payload_byte, output sequence_number,
                  output timestamp, output packet_end, output fragmented,
                  output run_last, input ready);
  modport sink (input valid, input payload_byte, input sequence_number,
                input timestamp, input packet_end, input fragmented,
                input run_last, output ready);
endinterface

interface hfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hfa_pkg::CFG_IDX_W-1:0]  index;
  logic [hfa_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/h264_rtp_fu_a_packetizer.sv @@
// H.264 RTP FU-A packetizer, top level. Takes one NAL unit byte per request
// and gives RTP payload bytes tagged with sequence number and timestamp.
// Unit bytes are accepted one per cycle while the queue has room; each
// fragment start adds the FU indicator and FU header ahead of up to m data
// bytes, m being max_payload (at least 16), and the single output byte
// lane carries one byte per cycle while out_o is ready. A four-entry queue
// lets the input keep flowing while the prefix bytes go out, and a result
// that waits on out_o does not block the input until the queue fills.
// Configuration writes are taken at any time but belong in idle periods.
// Depends on hfa_pkg, hfa_if, hfa_front, hfa_queue and hfa_back.
module h264_rtp_fu_a_packetizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfa_in_if.sink    in_i,
  hfa_cfg_if.sink   cfg_i,
  hfa_out_if.source out_o
);
  import hfa_pkg::*;

  logic     push_valid;
  logic     push_ready;
  hfa_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  hfa_cmd_t pop_cmd;

  hfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  hfa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  hfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_o       (out_o)
  );

endmodule

@@ rtl/hfa_front.sv @@
// Front end: configuration registers, unit tracking and per-byte request
// classification into queue commands. Depends on hfa_pkg and hfa_if.
module hfa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  hfa_in_if.sink            in_i,
  hfa_cfg_if.sink           cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output hfa_pkg::hfa_cmd_t push_cmd_o
);
  import hfa_pkg::*;

  logic [MAXP_W-1:0] max_payload_q;
  logic [STEP_W-1:0] ts_step_q;
  logic              skip_q;

  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [7:0]        header_q, header_d;
  logic [MAXP_W-1:0] unit_max_q, unit_max_d;
  logic              split_q, split_d;
  logic [MAXP_W-1:0] frag_off_q, frag_off_d;
  logic              first_frag_q, first_frag_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [TS_W-1:0]   ts_q, ts_d;

  logic              accept;
  logic              emit;
  logic              unit_done;
  logic [7:0]        unit_hdr;
  logic [LEN_W-1:0]  len;
  logic [MAXP_W-1:0] m_eff;
  logic [MAXP_W:0]   off_inc;
  logic [7:0]        fh;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = push_ready_i;
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAXP_RESET;
      ts_step_q     <= STEP_RESET;
      skip_q        <= SKIP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_i.data[MAXP_W-1:0];
        CFG_TS_STEP:     ts_step_q     <= cfg_i.data[STEP_W-1:0];
        CFG_SKIP_PSETS:  skip_q        <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len = in_i.unit_length;
    if (len == '0) begin
      len = LEN_W'(1);
    end else if (len > MAX_UNIT_BYTES) begin
      len = MAX_UNIT_BYTES;
    end
    m_eff   = (max_payload_q < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_q;
    off_inc = {1'b0, frag_off_q} + (MAXP_W+1)'(1);
    fh      = header_q & TYPE_MASK;
    if (remain_q <= LEN_W'(unit_max_q)) begin
      fh = fh | FU_E_BIT;
    end else if (first_frag_q) begin
      fh = fh | FU_S_BIT;
    end

    remain_d     = remain_q;
    header_d     = header_q;
    unit_max_d   = unit_max_q;
    split_d      = split_q;
    frag_off_d   = frag_off_q;
    first_frag_d = first_frag_q;
    unit_hdr     = header_q;
    unit_done    = 1'b0;
    emit         = 1'b0;

    push_cmd_o.data    = in_i.unit_byte;
    push_cmd_o.fu_ind  = (header_q & NRI_MASK) | FU_A_TYPE;
    push_cmd_o.fu_hdr  = fh;
    push_cmd_o.prefix  = 1'b0;
    push_cmd_o.pkt_end = 1'b0;
    push_cmd_o.frag    = 1'b0;
    push_cmd_o.seq     = seq_q;
    push_cmd_o.ts      = ts_q;

    if (remain_q == '0) begin
      header_d     = in_i.unit_byte;
      unit_hdr     = in_i.unit_byte;
      unit_max_d   = m_eff;
      split_d      = len > LEN_W'(m_eff);
      frag_off_d   = '0;
      first_frag_d = 1'b1;
      remain_d     = len - LEN_W'(1);
      unit_done    = (len == LEN_W'(1));
      emit         = !split_d;
      push_cmd_o.pkt_end = unit_done;
    end else begin
      remain_d  = remain_q - LEN_W'(1);
      unit_done = (remain_q == LEN_W'(1));
      emit      = 1'b1;
      if (!split_q) begin
        push_cmd_o.pkt_end = unit_done;
      end else begin
        push_cmd_o.frag    = 1'b1;
        push_cmd_o.prefix  = (frag_off_q == '0);
        push_cmd_o.pkt_end = (off_inc >= {1'b0, unit_max_q}) || unit_done;
        if (push_cmd_o.pkt_end) begin
          frag_off_d   = '0;
          first_frag_d = 1'b0;
        end else begin
          frag_off_d = off_inc[MAXP_W-1:0];
        end
      end
    end
    if (unit_done) begin
      frag_off_d = '0;
    end

    seq_d = seq_q;
    ts_d  = ts_q;
    if (accept) begin
      if (emit && push_cmd_o.pkt_end) begin
        seq_d = seq_q + SEQ_W'(1);
      end
      if (unit_done && !(skip_q && (unit_hdr[4:0] == NAL_SPS ||
                                    unit_hdr[4:0] == NAL_PPS))) begin
        ts_d = ts_q + TS_W'(ts_step_q);
      end
    end
  end

  assign push_valid_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q     <= '0;
      header_q     <= '0;
      unit_max_q   <= '0;
      split_q      <= 1'b0;
      frag_off_q   <= '0;
      first_frag_q <= 1'b0;
      seq_q        <= '0;
      ts_q         <= '0;
    end else begin
      seq_q <= seq_d;
      ts_q  <= ts_d;
      if (accept) begin
        remain_q     <= remain_d;
        header_q     <= header_d;
        unit_max_q   <= unit_max_d;
        split_q      <= split_d;
        frag_off_q   <= frag_off_d;
        first_frag_q <= first_frag_d;
      end
    end
  end

endmodule

@@ rtl/hfa_queue.sv @@
// Command queue between front and back end, QDEPTH (four) entries deep.
// Depends on hfa_pkg.
module hfa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  hfa_pkg::hfa_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output hfa_pkg::hfa_cmd_t pop_cmd_o
);
  import hfa_pkg::*;

  hfa_cmd_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q < QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue count missed a push");
`endif

endmodule

@@ rtl/hfa_back.sv @@
// Back end: expands queue commands into FU indicator, FU header and data
// bytes through a registered output stage. Depends on hfa_pkg and hfa_if.
module hfa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  hfa_pkg::hfa_cmd_t cmd_i,
  hfa_out_if.source         out_o
);
  import hfa_pkg::*;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_HDR   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic [SEQ_W-1:0] oseq_q;
  logic [TS_W-1:0]  ots_q;
  logic             oend_q, oend_d;
  logic             ofrag_q;
  logic             olast_q, olast_d;
  logic             load;

  assign load = !ovalid_q || out_o.ready;

  always_comb begin
    phase_d     = phase_q;
    ovalid_d    = ovalid_q;
    obyte_d     = cmd_i.data;
    oend_d      = cmd_i.pkt_end;
    olast_d     = 1'b1;
    cmd_ready_o = 1'b0;
    if (load) begin
      ovalid_d = cmd_valid_i;
      if (cmd_valid_i) begin
        unique case (phase_q)
          PH_FIRST: begin
            if (cmd_i.prefix) begin
              obyte_d = cmd_i.fu_ind;
              oend_d  = 1'b0;
              olast_d = 1'b0;
              phase_d = PH_HDR;
            end else begin
              cmd_ready_o = 1'b1;
            end
          end
          PH_HDR: begin
            obyte_d = cmd_i.fu_hdr;
            oend_d  = 1'b0;
            olast_d = 1'b0;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            cmd_ready_o = 1'b1;
            phase_d     = PH_FIRST;
          end
          default: begin
            phase_d = PH_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && cmd_valid_i) begin
      obyte_q <= obyte_d;
      oseq_q  <= cmd_i.seq;
      ots_q   <= cmd_i.ts;
      oend_q  <= oend_d;
      ofrag_q <= cmd_i.frag;
      olast_q <= olast_d;
    end
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.payload_byte    = obyte_q;
  assign out_o.sequence_number = oseq_q;
  assign out_o.timestamp       = ots_q;
  assign out_o.packet_end      = oend_q;
  assign out_o.fragmented      = ofrag_q;
  assign out_o.run_last        = olast_q;

`ifndef SYNTHESIS
  a_prefix_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_FIRST) |-> cmd_valid_i)
    else $error("prefix in progress without a queued command");

  a_end_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oend_q) |-> olast_q)
    else $error("packet end on a prefix byte");
`endif

endmodule
